### rtl/core/trwu_pkg.sv
// ----------------------------------------------------------------------------
// trwu_pkg
// Shared types and constants of the tracker readout word unpacker.
// ----------------------------------------------------------------------------
package trwu_pkg;

  // Word that opens every readout block
  localparam logic [31:0] HEADER_WORD = 32'h0000_0200;
  localparam logic [31:0] FILL_WORD   = 32'hFFFF_FFFF;

  // Type bits 31:30 of the first word of a pair
  localparam logic [1:0] TYPE_HIT  = 2'b11;
  localparam logic [1:0] TYPE_INFO = 2'b10;

  // Info codes, bits 23:20 of the first info word
  localparam logic [3:0] INFO_LOCAL_MIDDLE_A = 4'd4;
  localparam logic [3:0] INFO_LOCAL_MIDDLE_B = 4'd7;
  localparam logic [3:0] INFO_LOCAL_UPPER_A  = 4'd5;
  localparam logic [3:0] INFO_LOCAL_UPPER_B  = 4'd8;
  localparam logic [3:0] INFO_EXT_MIDDLE     = 4'd14;
  localparam logic [3:0] INFO_EXT_UPPER      = 4'd15;

  localparam logic [15:0] HIT_COUNT_MAX = 16'hFFFF;

  // Number of reference timestamp word slots, loaded one-hot
  localparam int unsigned REF_WORDS = 4;

  // Block parser phase, one-hot
  typedef enum logic [8:0] {
    PH_HEADER = 9'b0_0000_0001,
    PH_REF1   = 9'b0_0000_0010,
    PH_REF2   = 9'b0_0000_0100,
    PH_REF3   = 9'b0_0000_1000,
    PH_REF4   = 9'b0_0001_0000,
    PH_PAIR   = 9'b0_0010_0000,
    PH_HIT2   = 9'b0_0100_0000,
    PH_INFO2  = 9'b0_1000_0000,
    PH_SKIP   = 9'b1_0000_0000
  } phase_t;

  // Timestamp register controls from the parser
  typedef struct packed {
    logic                 block_start;
    logic [REF_WORDS-1:0] ref_load;
    logic                 info_load;
  } stamp_ctrl_t;

endpackage

### rtl/core/trwu_stamp.sv
// ----------------------------------------------------------------------------
// trwu_stamp
// Timestamp state: reference stamp, local and external high parts, external
// low bits and the latest info word. Builds the 64-bit hit and external times.
// ----------------------------------------------------------------------------
module trwu_stamp (
  input  logic                 clk,
  input  logic                 rst,
  input  trwu_pkg::stamp_ctrl_t ctrl,
  input  logic [31:0]          word,
  input  logic [29:0]          pending,
  output logic [63:0]          reference_stamp,
  output logic [63:0]          hit_time,
  output logic [63:0]          external_time,
  output logic [23:0]          last_info
);

  logic [15:0] local_high_upper;
  logic [19:0] local_high_middle;
  logic [15:0] external_high_upper;
  logic [19:0] external_high_middle;
  logic [27:0] external_low;
  logic [3:0]  info_sel;
  logic [19:0] info_data;

  assign info_sel  = pending[23:20];
  assign info_data = pending[19:0];

  // Load reference slots, clear at block start
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_stamp <= '0;
    end else if (ctrl.block_start) begin
      reference_stamp <= '0;
    end else begin
      for (int i = 0; i < trwu_pkg::REF_WORDS; i++) begin
        if (ctrl.ref_load[i]) begin
          reference_stamp[i*16 +: 16] <= word[15:0];
        end
      end
    end
  end

  // Update high parts, external low bits and the latest info word from info pairs; clear the high parts at block start
  always_ff @(posedge clk) begin
    if (rst) begin
      local_high_upper     <= '0;
      local_high_middle    <= '0;
      external_high_upper  <= '0;
      external_high_middle <= '0;
      external_low         <= '0;
      last_info            <= '0;
    end else if (ctrl.block_start) begin
      local_high_upper     <= '0;
      local_high_middle    <= '0;
      external_high_upper  <= '0;
      external_high_middle <= '0;
    end else if (ctrl.info_load) begin
      case (info_sel)
        trwu_pkg::INFO_LOCAL_MIDDLE_A,
        trwu_pkg::INFO_LOCAL_MIDDLE_B: begin
          local_high_middle <= info_data;
        end
        trwu_pkg::INFO_LOCAL_UPPER_A,
        trwu_pkg::INFO_LOCAL_UPPER_B: begin
          local_high_upper <= info_data[15:0];
        end
        trwu_pkg::INFO_EXT_MIDDLE: begin
          external_high_middle <= info_data;
        end
        trwu_pkg::INFO_EXT_UPPER: begin
          external_high_upper <= info_data[15:0];
        end
        default: begin
        end
      endcase
      external_low <= word[27:0];
      last_info    <= {info_sel, info_data};
    end
  end

  // Join high parts with low bits
  assign hit_time      = {local_high_upper, local_high_middle, word[27:0]};
  assign external_time = {external_high_upper, external_high_middle, external_low};

endmodule

### rtl/core/tracker_readout_word_unpacker_unit.sv
// ----------------------------------------------------------------------------
// tracker_readout_word_unpacker_unit
// Parses readout blocks word by word and emits one result per hit pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (word_valid / word_stall) carries one 32-bit readout word
//   and block_end, which marks the last word of a block. A block opens with
//   the header word, then four reference timestamp words, then word pairs.
//   Output channel (hit_valid / hit_stall) carries one hit record per hit
//   pair: decoded hit fields, reference time, 64-bit hit time, external
//   time, the latest info word and the running hit number.
//   Throughput: one word per cycle. Each word is parsed by one pass of
//   logic straight into the state and result registers.
//   A hit record is valid in the cycle after its second word is accepted.
//   Stall: the result register holds a record until taken; while a record
//   waits under hit_stall, word_stall is raised and no word is taken.
//   Reset (rst, synchronous): the parser waits for a header, all timestamp
//   parts, the info word and the hit counter clear, no record is valid.
//   A word that is not the header at block start makes the block skipped
//   up to its block_end word.
// ----------------------------------------------------------------------------
module tracker_readout_word_unpacker_unit (
  input  logic        clk,
  input  logic        rst,
  // word requests
  input  logic        word_valid,
  output logic        word_stall,
  input  logic [31:0] word,
  input  logic        block_end,
  // hit records
  output logic        hit_valid,
  input  logic        hit_stall,
  output logic [63:0] reference_time,
  output logic        hit_flag,
  output logic [4:0]  module_number,
  output logic        sensor_side,
  output logic [3:0]  chip_number,
  output logic [6:0]  strip_number,
  output logic [11:0] adc_value,
  output logic [63:0] hit_time,
  output logic [63:0] external_time,
  output logic [19:0] info_value,
  output logic [3:0]  info_kind,
  output logic [15:0] hit_number
);

  trwu_pkg::phase_t      phase;
  trwu_pkg::phase_t      phase_next;
  trwu_pkg::stamp_ctrl_t stamp_ctrl;
  logic [29:0]           pending;
  logic [15:0]           hit_count;
  logic                  word_accept;
  logic                  pair_start;
  logic                  hit_done;
  logic [63:0]           stamp_reference;
  logic [63:0]           stamp_hit_time;
  logic [63:0]           stamp_external_time;
  logic [23:0]           stamp_last_info;

  assign word_stall  = hit_valid && hit_stall;
  assign word_accept = word_valid && !word_stall;
  assign pair_start  = (phase == trwu_pkg::PH_PAIR) && (word != trwu_pkg::FILL_WORD)
                       && ((word[31:30] == trwu_pkg::TYPE_HIT)
                           || (word[31:30] == trwu_pkg::TYPE_INFO));
  assign hit_done    = word_accept && (phase == trwu_pkg::PH_HIT2);

  // Work out the next phase and timestamp controls
  always_comb begin
    phase_next = phase;
    stamp_ctrl = '0;
    case (phase)
      trwu_pkg::PH_HEADER: begin
        if (word == trwu_pkg::HEADER_WORD) begin
          phase_next             = trwu_pkg::PH_REF1;
          stamp_ctrl.block_start = 1'b1;
        end else begin
          phase_next = trwu_pkg::PH_SKIP;
        end
      end
      trwu_pkg::PH_REF1: begin
        phase_next             = trwu_pkg::PH_REF2;
        stamp_ctrl.ref_load[0] = 1'b1;
      end
      trwu_pkg::PH_REF2: begin
        phase_next             = trwu_pkg::PH_REF3;
        stamp_ctrl.ref_load[1] = 1'b1;
      end
      trwu_pkg::PH_REF3: begin
        phase_next             = trwu_pkg::PH_REF4;
        stamp_ctrl.ref_load[2] = 1'b1;
      end
      trwu_pkg::PH_REF4: begin
        phase_next             = trwu_pkg::PH_PAIR;
        stamp_ctrl.ref_load[3] = 1'b1;
      end
      trwu_pkg::PH_PAIR: begin
        if (pair_start) begin
          phase_next = (word[31:30] == trwu_pkg::TYPE_HIT) ? trwu_pkg::PH_HIT2
                                                           : trwu_pkg::PH_INFO2;
        end
      end
      trwu_pkg::PH_HIT2: begin
        phase_next = trwu_pkg::PH_PAIR;
      end
      trwu_pkg::PH_INFO2: begin
        phase_next           = trwu_pkg::PH_PAIR;
        stamp_ctrl.info_load = 1'b1;
      end
      default: begin
        phase_next = trwu_pkg::PH_SKIP;
      end
    endcase
    if (block_end) begin
      phase_next = trwu_pkg::PH_HEADER;
    end
    if (!word_accept) begin
      phase_next = phase;
      stamp_ctrl = '0;
    end
  end

  trwu_stamp u_stamp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (stamp_ctrl),
    .word            (word),
    .pending         (pending),
    .reference_stamp (stamp_reference),
    .hit_time        (stamp_hit_time),
    .external_time   (stamp_external_time),
    .last_info       (stamp_last_info)
  );

  // Advance the parser phase
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= trwu_pkg::PH_HEADER;
    end else begin
      phase <= phase_next;
    end
  end

  // Hold the first word of a pair
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (word_accept && pair_start) begin
      pending <= word[29:0];
    end
  end

  // Count hits, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count <= '0;
    end else if (hit_done && (hit_count != trwu_pkg::HIT_COUNT_MAX)) begin
      hit_count <= hit_count + 16'd1;
    end
  end

  // Result register valid: load on a finished hit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (hit_done) begin
      hit_valid <= 1'b1;
    end else if (!hit_stall) begin
      hit_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (hit_done) begin
      reference_time <= stamp_reference;
      hit_flag       <= pending[29];
      module_number  <= pending[28:24];
      sensor_side    <= pending[23];
      chip_number    <= pending[22:19];
      strip_number   <= pending[18:12];
      adc_value      <= pending[11:0];
      hit_time       <= stamp_hit_time;
      external_time  <= stamp_external_time;
      info_value     <= stamp_last_info[19:0];
      info_kind      <= stamp_last_info[23:20];
      hit_number     <= hit_count;
    end
  end

  // A new record only follows the second word of a hit pair
  a_record_from_hit_pair: assert property (@(posedge clk) disable iff (rst)
    $rose(hit_valid) |-> $past(word_accept && (phase == trwu_pkg::PH_HIT2)))
    else $error("hit record without a hit pair");

  // The last word of a block always returns the parser to the header
  a_block_end_header: assert property (@(posedge clk) disable iff (rst)
    (word_accept && block_end) |=> (phase == trwu_pkg::PH_HEADER))
    else $error("block end did not return to header");

  // Each hit below saturation bumps the counter by one
  a_hit_count_step: assert property (@(posedge clk) disable iff (rst)
    (hit_done && (hit_count != trwu_pkg::HIT_COUNT_MAX))
      |=> (hit_count == $past(hit_count) + 16'd1))
    else $error("hit counter did not advance");

  // A loaded record carries the count seen at its second word
  a_record_number: assert property (@(posedge clk) disable iff (rst)
    hit_done |=> (hit_valid && (hit_number == $past(hit_count))))
    else $error("hit record number mismatch");

  // A wrong header sends the block to skip
  a_bad_header_skip: assert property (@(posedge clk) disable iff (rst)
    (word_accept && !block_end && (phase == trwu_pkg::PH_HEADER)
      && (word != trwu_pkg::HEADER_WORD)) |=> (phase == trwu_pkg::PH_SKIP))
    else $error("bad header not skipped");

endmodule

### tb/sv/tracker_readout_word_unpacker_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tracker_readout_word_unpacker_unit_tb
// Self-checking bench for the readout word unpacker. Readout blocks are fed
// word by word in random bursts. A block parser written in this file
// predicts every hit record, and each record taken from the block is checked
// field by field against the oldest prediction. The receiver stalls on
// shifting patterns, with one long hold-off.
// ----------------------------------------------------------------------------
module tracker_readout_word_unpacker_unit_tb;

  localparam int unsigned RANDOM_WORDS     = 1820;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned HOLD_START       = 400;
  localparam int unsigned HOLD_CYCLES      = 500;
  localparam int unsigned MAX_REPORTS      = 50;

  typedef struct {
    logic [31:0] word;
    logic        last;
  } word_request_t;

  typedef struct {
    logic [63:0] reference_time;
    logic        hit_flag;
    logic [4:0]  module_number;
    logic        sensor_side;
    logic [3:0]  chip_number;
    logic [6:0]  strip_number;
    logic [11:0] adc_value;
    logic [63:0] hit_time;
    logic [63:0] external_time;
    logic [19:0] info_value;
    logic [3:0]  info_kind;
    logic [15:0] hit_number;
  } hit_record_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        word_valid = 1'b0;
  logic        word_stall;
  logic [31:0] word       = '0;
  logic        block_end  = 1'b0;
  logic        hit_valid;
  logic        hit_stall  = 1'b0;
  logic [63:0] reference_time;
  logic        hit_flag;
  logic [4:0]  module_number;
  logic        sensor_side;
  logic [3:0]  chip_number;
  logic [6:0]  strip_number;
  logic [11:0] adc_value;
  logic [63:0] hit_time;
  logic [63:0] external_time;
  logic [19:0] info_value;
  logic [3:0]  info_kind;
  logic [15:0] hit_number;

  word_request_t word_requests[$];
  hit_record_t   expected_hits[$];
  int unsigned   mismatch_count = 0;
  int unsigned   records_taken  = 0;
  int unsigned   cycle_count    = 0;

  // Sender and receiver pacing
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned stall_tick = 0;
  int unsigned hold_clock = 0;
  logic        hold_off   = 1'b0;
  logic        stall_now;

  // Parser state of the prediction
  trwu_pkg::phase_t parse_phase = trwu_pkg::PH_HEADER;
  logic [63:0] ref_stamp   = '0;
  logic [29:0] pair_head   = '0;
  logic [15:0] loc_upper   = '0;
  logic [19:0] loc_middle  = '0;
  logic [15:0] ext_upper   = '0;
  logic [19:0] ext_middle  = '0;
  logic [27:0] ext_low     = '0;
  logic [23:0] info_latest = '0;
  logic [15:0] hits_seen   = '0;

  tracker_readout_word_unpacker_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .word_valid     (word_valid),
    .word_stall     (word_stall),
    .word           (word),
    .block_end      (block_end),
    .hit_valid      (hit_valid),
    .hit_stall      (hit_stall),
    .reference_time (reference_time),
    .hit_flag       (hit_flag),
    .module_number  (module_number),
    .sensor_side    (sensor_side),
    .chip_number    (chip_number),
    .strip_number   (strip_number),
    .adc_value      (adc_value),
    .hit_time       (hit_time),
    .external_time  (external_time),
    .info_value     (info_value),
    .info_kind      (info_kind),
    .hit_number     (hit_number)
  );

  always #5 clk = ~clk;

  // Advance the parser by one accepted word and queue any hit record it yields
  task automatic predict_hits(input logic [31:0] w, input logic last);
    hit_record_t rec;
    logic [3:0]  code;
    logic [19:0] field;
    case (parse_phase)
      trwu_pkg::PH_HEADER: begin
        if (w == trwu_pkg::HEADER_WORD) begin
          ref_stamp   = '0;
          loc_upper   = '0;
          loc_middle  = '0;
          ext_upper   = '0;
          ext_middle  = '0;
          parse_phase = trwu_pkg::PH_REF1;
        end else begin
          parse_phase = trwu_pkg::PH_SKIP;
        end
      end
      trwu_pkg::PH_REF1: begin
        ref_stamp[15:0] = w[15:0];
        parse_phase = trwu_pkg::PH_REF2;
      end
      trwu_pkg::PH_REF2: begin
        // bits 15:12 land on 31:28 and 11:0 on 27:16, so the slice is contiguous
        ref_stamp[31:16] = w[15:0];
        parse_phase = trwu_pkg::PH_REF3;
      end
      trwu_pkg::PH_REF3: begin
        ref_stamp[47:32] = w[15:0];
        parse_phase = trwu_pkg::PH_REF4;
      end
      trwu_pkg::PH_REF4: begin
        ref_stamp[63:48] = w[15:0];
        parse_phase = trwu_pkg::PH_PAIR;
      end
      trwu_pkg::PH_PAIR: begin
        if (w != trwu_pkg::FILL_WORD && w[31:30] == trwu_pkg::TYPE_HIT) begin
          pair_head   = w[29:0];
          parse_phase = trwu_pkg::PH_HIT2;
        end else if (w != trwu_pkg::FILL_WORD && w[31:30] == trwu_pkg::TYPE_INFO) begin
          pair_head   = w[29:0];
          parse_phase = trwu_pkg::PH_INFO2;
        end
      end
      trwu_pkg::PH_HIT2: begin
        rec.reference_time = ref_stamp;
        rec.hit_flag       = pair_head[29];
        rec.module_number  = pair_head[28:24];
        rec.sensor_side    = pair_head[23];
        rec.chip_number    = pair_head[22:19];
        rec.strip_number   = pair_head[18:12];
        rec.adc_value      = pair_head[11:0];
        rec.hit_time       = {loc_upper, loc_middle, w[27:0]};
        rec.external_time  = {ext_upper, ext_middle, ext_low};
        rec.info_value     = info_latest[19:0];
        rec.info_kind      = info_latest[23:20];
        rec.hit_number     = hits_seen;
        expected_hits.push_back(rec);
        if (hits_seen != trwu_pkg::HIT_COUNT_MAX) hits_seen = hits_seen + 16'd1;
        parse_phase = trwu_pkg::PH_PAIR;
      end
      trwu_pkg::PH_INFO2: begin
        code  = pair_head[23:20];
        field = pair_head[19:0];
        case (code)
          trwu_pkg::INFO_LOCAL_MIDDLE_A, trwu_pkg::INFO_LOCAL_MIDDLE_B: loc_middle = field;
          trwu_pkg::INFO_LOCAL_UPPER_A, trwu_pkg::INFO_LOCAL_UPPER_B:   loc_upper  = field[15:0];
          trwu_pkg::INFO_EXT_MIDDLE:                                    ext_middle = field;
          trwu_pkg::INFO_EXT_UPPER:                                     ext_upper  = field[15:0];
          default: ;
        endcase
        ext_low     = w[27:0];
        info_latest = {code, field};
        parse_phase = trwu_pkg::PH_PAIR;
      end
      default: parse_phase = trwu_pkg::PH_SKIP;
    endcase
    // any block end sends the parser back to header search
    if (last) parse_phase = trwu_pkg::PH_HEADER;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("hit record %0d: %s got %h expected %h", records_taken, what, got, want);
  endtask

  task automatic queue_word(input logic [31:0] w, input logic last);
    word_request_t req;
    req.word = w;
    req.last = last;
    word_requests.push_back(req);
  endtask

  // Offer word requests in bursts; hold the payload while stalled
  always @(posedge clk) begin : sender
    word_request_t req;
    if (rst) begin
      word_valid <= 1'b0;
      word       <= '0;
      block_end  <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      if (word_valid && !word_stall) predict_hits(word, block_end);
      if (!word_valid || !word_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          word_valid <= 1'b0;
        end else if (word_requests.size() != 0) begin
          req = word_requests.pop_front();
          word       <= req.word;
          block_end  <= req.last;
          word_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
          end
        end else begin
          word_valid <= 1'b0;
        end
      end
    end
  end

  // Raise one long hold-off on the receiver so the block backs up
  always @(posedge clk) begin : hold_timer
    if (rst) begin
      hold_clock = 0;
      hold_off   <= 1'b0;
    end else begin
      hold_clock++;
      hold_off <= (hold_clock >= HOLD_START) && (hold_clock < HOLD_START + HOLD_CYCLES);
    end
  end

  // Take hit records, check them, and stall on a shifting pattern
  always @(posedge clk) begin : monitor
    hit_record_t want;
    if (rst) begin
      hit_stall <= 1'b0;
    end else begin
      if (hit_valid && !hit_stall) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("hit_valid with none pending", 64'd1, 64'd0);
        end else begin
          want = expected_hits.pop_front();
          if (reference_time !== want.reference_time)
            report_mismatch("reference_time", reference_time, want.reference_time);
          if (hit_flag !== want.hit_flag)
            report_mismatch("hit_flag", 64'(hit_flag), 64'(want.hit_flag));
          if (module_number !== want.module_number)
            report_mismatch("module_number", 64'(module_number), 64'(want.module_number));
          if (sensor_side !== want.sensor_side)
            report_mismatch("sensor_side", 64'(sensor_side), 64'(want.sensor_side));
          if (chip_number !== want.chip_number)
            report_mismatch("chip_number", 64'(chip_number), 64'(want.chip_number));
          if (strip_number !== want.strip_number)
            report_mismatch("strip_number", 64'(strip_number), 64'(want.strip_number));
          if (adc_value !== want.adc_value)
            report_mismatch("adc_value", 64'(adc_value), 64'(want.adc_value));
          if (hit_time !== want.hit_time)
            report_mismatch("hit_time", hit_time, want.hit_time);
          if (external_time !== want.external_time)
            report_mismatch("external_time", external_time, want.external_time);
          if (info_value !== want.info_value)
            report_mismatch("info_value", 64'(info_value), 64'(want.info_value));
          if (info_kind !== want.info_kind)
            report_mismatch("info_kind", 64'(info_kind), 64'(want.info_kind));
          if (hit_number !== want.hit_number)
            report_mismatch("hit_number", 64'(hit_number), 64'(want.hit_number));
        end
        records_taken++;
      end
      // switch stall style when the current mode runs out
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      stall_tick++;
      case (stall_mode)
        0:       stall_now = 1'b0;
        1:       stall_now = ($urandom_range(0, 3) == 0);
        2:       stall_now = ($urandom_range(0, 9) < 7);
        default: stall_now = ((stall_tick % 5) < 2);
      endcase
      hit_stall <= hold_off || stall_now;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] blk[$];
    logic [31:0] rnd;
    logic [31:0] rnd2;
    logic [3:0]  code;
    int unsigned keep;
    int unsigned pairs;
    int unsigned shape;
    int unsigned random_words;

    // Short block: ends inside the reference timestamp words
    queue_word(trwu_pkg::HEADER_WORD, 1'b0);
    queue_word(32'hFFFF_FFFF, 1'b0);
    queue_word(32'h0000_1234, 1'b1);
    // Wrong header: the hit pair behind it must be ignored
    queue_word(32'h0000_0201, 1'b0);
    queue_word(32'hFFFF_FFFE, 1'b0);
    queue_word(32'h0000_0000, 1'b1);
    // Full block with extreme reference words
    queue_word(trwu_pkg::HEADER_WORD, 1'b0);
    queue_word(32'hABCD_FFFF, 1'b0);
    queue_word(32'h0000_F000, 1'b0);
    queue_word(32'hFFFF_0000, 1'b0);
    queue_word(32'h1234_8001, 1'b0);
    // Load each high timestamp part
    queue_word({trwu_pkg::TYPE_INFO, 6'h3F, trwu_pkg::INFO_LOCAL_MIDDLE_A, 20'hFFFFF}, 1'b0);
    queue_word(32'hFFFF_FFFF, 1'b0);
    queue_word({trwu_pkg::TYPE_INFO, 6'h00, trwu_pkg::INFO_LOCAL_UPPER_A, 20'hFFFFF}, 1'b0);
    queue_word(32'h0000_0001, 1'b0);
    queue_word({trwu_pkg::TYPE_INFO, 6'h15, trwu_pkg::INFO_EXT_MIDDLE, 20'hA5A5A}, 1'b0);
    queue_word(32'hF000_0000, 1'b0);
    queue_word({trwu_pkg::TYPE_INFO, 6'h2A, trwu_pkg::INFO_EXT_UPPER, 20'h5FFFF}, 1'b0);
    queue_word(32'h0FFF_FFFF, 1'b0);
    // Hit with every field at maximum but ADC bit 0, then skipped words, then a zero hit
    queue_word(32'hFFFF_FFFE, 1'b0);
    queue_word(32'hFFFF_FFFF, 1'b0);
    queue_word(trwu_pkg::FILL_WORD, 1'b0);
    queue_word(32'h4000_0200, 1'b0);
    queue_word({trwu_pkg::TYPE_HIT, 30'h0}, 1'b0);
    queue_word(32'h0000_0000, 1'b0);
    // Cut-off pair: first hit word closes the block
    queue_word({trwu_pkg::TYPE_HIT, 30'h2AAA_AAAA}, 1'b1);

    // Random blocks: mostly well formed, some wrong headers, short or cut off
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      blk.delete();
      shape = $urandom_range(0, 19);
      if (shape == 0) begin
        rnd = $urandom();
        if (rnd[0]) blk.push_back(trwu_pkg::HEADER_WORD ^ (32'd1 << rnd[5:1]));
        else        blk.push_back(rnd);
        repeat ($urandom_range(0, 6)) begin
          rnd = $urandom();
          blk.push_back(rnd);
        end
      end else begin
        blk.push_back(trwu_pkg::HEADER_WORD);
        repeat (4) begin
          rnd = $urandom();
          blk.push_back(rnd);
        end
        pairs = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        repeat (pairs) begin
          rnd  = $urandom();
          rnd2 = $urandom();
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              blk.push_back({trwu_pkg::TYPE_HIT, rnd[29:0]});
              blk.push_back(rnd2);
            end
            5, 6, 7, 8: begin
              case ($urandom_range(0, 7))
                0:       code = trwu_pkg::INFO_LOCAL_MIDDLE_A;
                1:       code = trwu_pkg::INFO_LOCAL_MIDDLE_B;
                2:       code = trwu_pkg::INFO_LOCAL_UPPER_A;
                3:       code = trwu_pkg::INFO_LOCAL_UPPER_B;
                4:       code = trwu_pkg::INFO_EXT_MIDDLE;
                5:       code = trwu_pkg::INFO_EXT_UPPER;
                default: code = rnd[23:20];
              endcase
              blk.push_back({trwu_pkg::TYPE_INFO, rnd[29:24], code, rnd[19:0]});
              blk.push_back(rnd2);
            end
            default: begin
              // lone word the parser skips
              case (rnd2[1:0])
                2'd0:    blk.push_back(trwu_pkg::FILL_WORD);
                2'd1:    blk.push_back(trwu_pkg::HEADER_WORD);
                default: blk.push_back({1'b0, rnd[30:0]});
              endcase
            end
          endcase
        end
        if (shape == 1) begin
          keep = $urandom_range(1, 5);
          while (blk.size() > keep) void'(blk.pop_back());
        end else if (shape == 2) begin
          rnd = $urandom();
          blk.push_back({rnd[31] ? trwu_pkg::TYPE_HIT : trwu_pkg::TYPE_INFO, rnd[29:0]});
        end
      end
      random_words += blk.size();
      foreach (blk[i]) queue_word(blk[i], i == blk.size() - 1);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Drain: every request taken and every record checked
    do @(negedge clk);
    while (word_requests.size() != 0 || word_valid || expected_hits.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_hits.size() != 0)
      report_mismatch("records never delivered", 64'd0, 64'(expected_hits.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### tracker_readout_word_unpacker_unit.f
rtl/core/trwu_pkg.sv
rtl/core/trwu_stamp.sv
rtl/core/tracker_readout_word_unpacker_unit.sv
tb/sv/tracker_readout_word_unpacker_unit_tb.sv
